[hw/rtl/alm_pkg.sv]
// shared types and codes for the array linked list manager
`timescale 1ns / 1ps

package alm_pkg;

   typedef enum logic [2:0] {
      ACT_APPEND   = 3'd0,
      ACT_PREPEND  = 3'd1,
      ACT_INSAFTER = 3'd2,
      ACT_DELETE   = 3'd3,
      ACT_FIND     = 3'd4,
      ACT_READ     = 3'd5,
      ACT_QUERY    = 3'd6,
      ACT_CLEAR    = 3'd7
   } alm_action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_NOTFOUND = 2'd2,
      STS_EMPTY    = 2'd3
   } alm_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_TAKE,
      ST_LINK1,
      ST_LINK2,
      ST_DEL1,
      ST_DEL2,
      ST_RESP
   } alm_state_type;

endpackage

[hw/rtl/array_linked_list_manager_unit.sv]
// Singly linked list of values kept in a slot store, with a free chain of unused slots.
// Each request beat on req_ names one action and gives exactly one response beat on rsp_.
// The links and values sit in two memories, each with one write port and one registered
// read port, and one sequencer walks the chain one slot per cycle. Find, read, delete and
// insert after walk from the head. Clear and reset both run a pass over the link memory
// that rebuilds the free chain. No request is taken during that pass, and none while a
// request is in work; a finished response waits in its output register while the next
// request starts.
`timescale 1ns / 1ps

module array_linked_list_manager_unit #(
   parameter int SLOTS      = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_value,
   input  logic [5:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_result_slot,
   output logic [15:0] rsp_result_value,
   output logic [5:0]  rsp_next_slot,
   output logic        rsp_has_next,
   output logic [5:0]  rsp_last_slot,
   output logic [6:0]  rsp_element_count,
   output logic        rsp_is_empty
);

   localparam int IW = $clog2(SLOTS);
   localparam int LW = IW + 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0] NONE = LW'(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // memories
   logic [LW-1:0]         link_mem [SLOTS];
   logic [VALUE_BITS-1:0] value_mem [SLOTS];
   logic [LW-1:0]         link_q_ff;
   logic [VALUE_BITS-1:0] value_q_ff;

   logic                  link_we;
   logic [IW-1:0]         link_wa;
   logic [LW-1:0]         link_wd;
   logic                  value_we;
   logic [IW-1:0]         rd_addr;

   // sequencer
   alm_pkg::alm_state_type state_ff, state_in;

   // list state
   logic [IW-1:0] head_ff;
   logic          list_ne_ff;
   logic [IW-1:0] fhead_ff;
   logic          free_ne_ff;
   logic [IW-1:0] tail_ff;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] clr_ff;
   logic          clr_rsp_ff;

   // request in work
   alm_pkg::alm_action_type act_ff;
   logic [VALUE_BITS-1:0]   v_ff;
   logic [5:0]              slot_ff;
   logic [LW-1:0]           cur_ff;
   logic [IW-1:0]           pred_ff;
   logic                    hp_ff;
   logic [LW-1:0]           alink_ff;
   logic [IW-1:0]           new_ff;

   // result in work
   alm_pkg::alm_status_type status_ff;
   logic [IW-1:0]           rslot_ff;
   logic [VALUE_BITS-1:0]   rval_ff;
   logic [IW-1:0]           nslot_ff;
   logic                    hnext_ff;

   // output register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [5:0]  rsp_rslot_ff;
   logic [15:0] rsp_rval_ff;
   logic [5:0]  rsp_nslot_ff;
   logic        rsp_hnext_ff;
   logic [5:0]  rsp_last_ff;
   logic [6:0]  rsp_count_ff;
   logic        rsp_empty_ff;

   alm_pkg::alm_action_type req_act;
   logic                    req_fire;
   logic                    walk_hit;
   logic                    walk_end;
   logic                    out_load;
   logic [IW-1:0]           cur_idx;

   assign req_act  = alm_pkg::alm_action_type'(req_action);
   assign req_fire = req_valid && req_ready;
   assign cur_idx  = cur_ff[IW-1:0];
   assign walk_hit = (act_ff == alm_pkg::ACT_FIND) ? (value_q_ff == v_ff)
                                                   : (32'(cur_ff) == 32'(slot_ff));
   assign walk_end = (link_q_ff == NONE);
   assign out_load = (state_ff == alm_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // memory ports
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (value_we) begin
         value_mem[new_ff] <= v_ff;
      end
      link_q_ff  <= link_mem[rd_addr];
      value_q_ff <= value_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alm_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = clr_rsp_ff ? alm_pkg::ST_RESP : alm_pkg::ST_IDLE;
            end
         end
         alm_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_act)
                  alm_pkg::ACT_APPEND, alm_pkg::ACT_PREPEND: begin
                     state_in = free_ne_ff ? alm_pkg::ST_TAKE : alm_pkg::ST_RESP;
                  end
                  alm_pkg::ACT_INSAFTER: begin
                     state_in = (free_ne_ff && list_ne_ff) ? alm_pkg::ST_WALK
                                                           : alm_pkg::ST_RESP;
                  end
                  alm_pkg::ACT_DELETE, alm_pkg::ACT_FIND, alm_pkg::ACT_READ: begin
                     state_in = list_ne_ff ? alm_pkg::ST_WALK : alm_pkg::ST_RESP;
                  end
                  alm_pkg::ACT_CLEAR: state_in = alm_pkg::ST_CLEAR;
                  default:            state_in = alm_pkg::ST_RESP;
               endcase
            end
         end
         alm_pkg::ST_WALK: begin
            if (walk_hit) begin
               case (act_ff)
                  alm_pkg::ACT_DELETE:   state_in = alm_pkg::ST_DEL1;
                  alm_pkg::ACT_INSAFTER: state_in = alm_pkg::ST_TAKE;
                  default:               state_in = alm_pkg::ST_RESP;
               endcase
            end else if (walk_end) begin
               state_in = alm_pkg::ST_RESP;
            end
         end
         alm_pkg::ST_TAKE: state_in = alm_pkg::ST_LINK1;
         alm_pkg::ST_LINK1: begin
            if ((act_ff == alm_pkg::ACT_INSAFTER) ||
                ((act_ff == alm_pkg::ACT_APPEND) && list_ne_ff)) begin
               state_in = alm_pkg::ST_LINK2;
            end else begin
               state_in = alm_pkg::ST_RESP;
            end
         end
         alm_pkg::ST_LINK2: state_in = alm_pkg::ST_RESP;
         alm_pkg::ST_DEL1:  state_in = alm_pkg::ST_DEL2;
         alm_pkg::ST_DEL2:  state_in = alm_pkg::ST_RESP;
         alm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = alm_pkg::ST_IDLE;
            end
         end
         default: state_in = alm_pkg::ST_CLEAR;
      endcase
   end

   // sequencer outputs: memory control and handshake
   always_comb begin
      link_we   = 1'b0;
      link_wa   = new_ff;
      link_wd   = NONE;
      value_we  = 1'b0;
      rd_addr   = head_ff;
      req_ready = 1'b0;
      case (state_ff)
         alm_pkg::ST_CLEAR: begin
            link_we = 1'b1;
            link_wa = clr_ff;
            link_wd = LW'(clr_ff) + LW'(1);
         end
         alm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = head_ff;
         end
         alm_pkg::ST_WALK: rd_addr = link_q_ff[IW-1:0];
         alm_pkg::ST_TAKE: rd_addr = fhead_ff;
         alm_pkg::ST_LINK1: begin
            value_we = 1'b1;
            link_we  = 1'b1;
            link_wa  = new_ff;
            case (act_ff)
               alm_pkg::ACT_PREPEND:  link_wd = list_ne_ff ? LW'(head_ff) : NONE;
               alm_pkg::ACT_INSAFTER: link_wd = alink_ff;
               default:               link_wd = NONE;
            endcase
         end
         alm_pkg::ST_LINK2: begin
            link_we = 1'b1;
            link_wa = (act_ff == alm_pkg::ACT_APPEND) ? tail_ff : cur_idx;
            link_wd = LW'(new_ff);
         end
         alm_pkg::ST_DEL1: begin
            link_we = hp_ff;
            link_wa = pred_ff;
            link_wd = alink_ff;
         end
         alm_pkg::ST_DEL2: begin
            link_we = 1'b1;
            link_wa = cur_idx;
            link_wd = free_ne_ff ? LW'(fhead_ff) : NONE;
         end
         default: begin
            link_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // list state, rebuilt on reset and on clear
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         list_ne_ff <= 1'b0;
         fhead_ff   <= '0;
         free_ne_ff <= 1'b1;
         tail_ff    <= '0;
         count_ff   <= '0;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
      end else begin
         case (state_ff)
            alm_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + IW'(1);
            end
            alm_pkg::ST_IDLE: begin
               if (req_fire && (req_act == alm_pkg::ACT_CLEAR)) begin
                  head_ff    <= '0;
                  list_ne_ff <= 1'b0;
                  fhead_ff   <= '0;
                  free_ne_ff <= 1'b1;
                  tail_ff    <= '0;
                  count_ff   <= '0;
                  clr_ff     <= '0;
                  clr_rsp_ff <= 1'b1;
               end
            end
            alm_pkg::ST_LINK1: begin
               // take the free head
               if (link_q_ff != NONE) begin
                  fhead_ff <= link_q_ff[IW-1:0];
               end else begin
                  fhead_ff   <= '0;
                  free_ne_ff <= 1'b0;
               end
               list_ne_ff <= 1'b1;
               count_ff   <= count_ff + CW'(1);
               case (act_ff)
                  alm_pkg::ACT_APPEND: begin
                     if (!list_ne_ff) begin
                        head_ff <= new_ff;
                        tail_ff <= new_ff;
                     end
                  end
                  alm_pkg::ACT_PREPEND: begin
                     head_ff <= new_ff;
                     if (!list_ne_ff) begin
                        tail_ff <= new_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            alm_pkg::ST_LINK2: begin
               if ((act_ff == alm_pkg::ACT_APPEND) || (cur_idx == tail_ff)) begin
                  tail_ff <= new_ff;
               end
            end
            alm_pkg::ST_DEL1: begin
               if (!hp_ff) begin
                  if (alink_ff != NONE) begin
                     head_ff <= alink_ff[IW-1:0];
                  end else begin
                     head_ff    <= '0;
                     list_ne_ff <= 1'b0;
                  end
               end
               if (cur_idx == tail_ff) begin
                  tail_ff <= hp_ff ? pred_ff : '0;
               end
               if (count_ff != '0) begin
                  count_ff <= count_ff - CW'(1);
               end
            end
            alm_pkg::ST_DEL2: begin
               fhead_ff   <= cur_idx;
               free_ne_ff <= 1'b1;
            end
            alm_pkg::ST_RESP: begin
               clr_rsp_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // request and result in work
   always_ff @(posedge clock) begin
      case (state_ff)
         alm_pkg::ST_IDLE: begin
            if (req_fire) begin
               act_ff    <= req_act;
               v_ff      <= VALUE_BITS'(req_value);
               slot_ff   <= req_slot;
               cur_ff    <= LW'(head_ff);
               hp_ff     <= 1'b0;
               status_ff <= alm_pkg::STS_OK;
               rslot_ff  <= '0;
               rval_ff   <= '0;
               nslot_ff  <= '0;
               hnext_ff  <= 1'b0;
               case (req_act)
                  alm_pkg::ACT_APPEND, alm_pkg::ACT_PREPEND: begin
                     if (!free_ne_ff) begin
                        status_ff <= alm_pkg::STS_FULL;
                     end
                  end
                  alm_pkg::ACT_INSAFTER: begin
                     if (!free_ne_ff) begin
                        status_ff <= alm_pkg::STS_FULL;
                     end else if (!list_ne_ff) begin
                        status_ff <= alm_pkg::STS_NOTFOUND;
                     end
                  end
                  alm_pkg::ACT_DELETE, alm_pkg::ACT_FIND, alm_pkg::ACT_READ: begin
                     if (!list_ne_ff) begin
                        status_ff <= alm_pkg::STS_EMPTY;
                     end
                  end
                  alm_pkg::ACT_QUERY: begin
                     rslot_ff <= list_ne_ff ? head_ff : '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         alm_pkg::ST_WALK: begin
            // read data in link_q_ff and value_q_ff belongs to cur_ff
            if (walk_hit) begin
               alink_ff <= link_q_ff;
               case (act_ff)
                  alm_pkg::ACT_FIND: rslot_ff <= cur_idx;
                  alm_pkg::ACT_READ: begin
                     rslot_ff <= cur_idx;
                     rval_ff  <= value_q_ff;
                     if (!walk_end) begin
                        nslot_ff <= link_q_ff[IW-1:0];
                        hnext_ff <= 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (walk_end) begin
               status_ff <= alm_pkg::STS_NOTFOUND;
            end else begin
               pred_ff <= cur_idx;
               hp_ff   <= 1'b1;
               cur_ff  <= link_q_ff;
            end
         end
         alm_pkg::ST_TAKE:  new_ff   <= fhead_ff;
         alm_pkg::ST_LINK1: rslot_ff <= new_ff;
         alm_pkg::ST_DEL2:  rslot_ff <= cur_idx;
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff <= status_ff;
         rsp_rslot_ff  <= 6'(rslot_ff);
         rsp_rval_ff   <= 16'(rval_ff);
         rsp_nslot_ff  <= 6'(nslot_ff);
         rsp_hnext_ff  <= hnext_ff;
         rsp_last_ff   <= list_ne_ff ? 6'(tail_ff) : 6'd0;
         rsp_count_ff  <= 7'(count_ff);
         rsp_empty_ff  <= !list_ne_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_slot   = rsp_rslot_ff;
   assign rsp_result_value  = rsp_rval_ff;
   assign rsp_next_slot     = rsp_nslot_ff;
   assign rsp_has_next      = rsp_hnext_ff;
   assign rsp_last_slot     = rsp_last_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;

endmodule
